### sv/mss_pkg.sv
`timescale 1ns / 1ps
package mss_pkg;

  localparam int DIGIT_BITS   = 32;
  localparam int BS_W         = $clog2(DIGIT_BITS);
  localparam int DS_W         = 6;
  localparam int LEN_W        = 13;
  localparam int IDX_W        = 13;
  localparam int INC_W        = DS_W + 1;
  localparam int MAX_DIGITS   = 4096;
  localparam int COUNT_MAX    = (1 << LEN_W) - 1;
  localparam int LEN_CAP_INT  = ((MAX_DIGITS + 63) > COUNT_MAX) ? COUNT_MAX : (MAX_DIGITS + 63);
  localparam logic [LEN_W-1:0] LEN_CAP    = LEN_W'(LEN_CAP_INT);
  localparam logic [DS_W-1:0]  DSHIFT_MAX = DS_W'(62);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_SHIFT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_SHIFT = 2'd2;

  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 2;

  // one classified input digit: a burst of zeros, then up to two digits
  typedef struct packed {
    logic [DS_W-1:0]       zeros;
    logic                  has_a;
    logic [DIGIT_BITS-1:0] a_digit;
    logic                  a_valid;
    logic                  has_b;
    logic [DIGIT_BITS-1:0] b_digit;
    logic                  last;
    logic [LEN_W-1:0]      length;
  } cmd_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit;
    logic                  digit_valid;
    logic                  end_of_number;
    logic [LEN_W-1:0]      length;
  } out_item_t;

endpackage

### sv/mss_fifo.sv
`timescale 1ns / 1ps
module mss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### sv/mss_front.sv
`timescale 1ns / 1ps
module mss_front import mss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic [DIGIT_BITS-1:0] in_digit,
  input  logic                  in_last_digit,
  input  logic                  cmd_full,
  output logic                  cmd_push,
  output cmd_t                  cmd
);

  logic                  shift_left_r;
  logic [BS_W-1:0]       bit_shift_r;
  logic [DS_W-1:0]       digit_shift_r;

  logic [DIGIT_BITS-1:0] held_r, held_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [LEN_W-1:0]      count_r, count_nxt;

  logic [DS_W-1:0]         ds;
  logic                    accept, first, kept, beyond, bs_zero;
  logic [2*DIGIT_BITS-1:0] lsh, rsh, csh;
  logic [DIGIT_BITS-1:0]   top;
  logic [INC_W-1:0]        inc;
  logic [LEN_W:0]          sum;
  logic [LEN_W-1:0]        count_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_left_r  <= 1'b0;
      bit_shift_r   <= '0;
      digit_shift_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHIFT_LEFT:  shift_left_r  <= cfg_data[0];
        CFG_BIT_SHIFT:   bit_shift_r   <= cfg_data[BS_W-1:0];
        CFG_DIGIT_SHIFT: digit_shift_r <= cfg_data[DS_W-1:0];
        default: ;
      endcase
    end
  end

  assign ds      = (digit_shift_r > DSHIFT_MAX) ? DSHIFT_MAX : digit_shift_r;
  assign accept  = push && !cmd_full;
  assign first   = (idx_r == '0);
  assign kept    = (idx_r >= IDX_W'(ds));
  assign beyond  = (idx_r > IDX_W'(ds));
  assign bs_zero = (bit_shift_r == '0);

  // funnel shifts across the held digit and the new one
  assign lsh = {in_digit, held_r} << bit_shift_r;
  assign csh = {{DIGIT_BITS{1'b0}}, in_digit} << bit_shift_r;
  assign rsh = {in_digit, held_r} >> bit_shift_r;
  assign top = in_digit >> bit_shift_r;

  always_comb begin
    cmd = '0;
    inc = '0;
    if (shift_left_r) begin
      cmd.zeros   = first ? ds : '0;
      cmd.has_a   = 1'b1;
      cmd.a_digit = lsh[2*DIGIT_BITS-1:DIGIT_BITS];
      cmd.a_valid = 1'b1;
      cmd.b_digit = csh[2*DIGIT_BITS-1:DIGIT_BITS];
      cmd.has_b   = in_last_digit && (cmd.b_digit != '0);
      inc = INC_W'(cmd.zeros) + INC_W'(1) + INC_W'(cmd.has_b);
    end else begin
      cmd.has_a   = kept && (bs_zero || beyond);
      cmd.a_digit = bs_zero ? in_digit : rsh[DIGIT_BITS-1:0];
      cmd.a_valid = 1'b1;
      cmd.b_digit = top;
      cmd.has_b   = kept && in_last_digit && !bs_zero && (top != '0);
      inc = INC_W'(cmd.has_a) + INC_W'(cmd.has_b);
      // number shifted away: one empty item
      if (in_last_digit && !cmd.has_a && !cmd.has_b) begin
        cmd.has_a   = 1'b1;
        cmd.a_digit = '0;
        cmd.a_valid = 1'b0;
      end
    end
    sum        = {1'b0, count_r} + (LEN_W + 1)'(inc);
    count_new  = (sum > (LEN_W + 1)'(LEN_CAP)) ? LEN_CAP : sum[LEN_W-1:0];
    cmd.last   = in_last_digit;
    cmd.length = count_new;
  end

  assign cmd_push = accept && (cmd.has_a || cmd.has_b);

  always_comb begin
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    if (accept) begin
      if (in_last_digit) begin
        held_nxt  = '0;
        idx_nxt   = '0;
        count_nxt = '0;
      end else begin
        held_nxt  = (shift_left_r || kept) ? in_digit : held_r;
        idx_nxt   = (idx_r == '1) ? idx_r : idx_r + 1'b1;
        count_nxt = count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### sv/mss_back.sv
`timescale 1ns / 1ps
module mss_back import mss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  input  logic      out_full,
  output logic      out_push,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    PH_LEAD = 2'b01,
    PH_TAIL = 2'b10
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [DS_W-1:0] zcnt_r, zcnt_nxt;

  logic in_zero, not_tail, sel_a, sel_b, item_final, go;

  always_comb begin
    unique case (phase_r)
      PH_LEAD: begin
        in_zero  = (zcnt_r != cmd.zeros);
        not_tail = 1'b1;
      end
      PH_TAIL: begin
        in_zero  = 1'b0;
        not_tail = 1'b0;
      end
      default: begin
        in_zero  = 1'b0;
        not_tail = 1'b0;
      end
    endcase
  end

  assign sel_a      = !in_zero && not_tail && cmd.has_a;
  assign sel_b      = !in_zero && !sel_a;
  assign item_final = sel_b || (sel_a && !cmd.has_b);
  assign go         = !cmd_empty && !out_full;
  assign out_push   = go;
  assign cmd_pop    = go && item_final;

  always_comb begin
    out_item               = '0;
    out_item.digit         = in_zero ? '0 : (sel_a ? cmd.a_digit : cmd.b_digit);
    out_item.digit_valid   = sel_a ? cmd.a_valid : 1'b1;
    out_item.end_of_number = item_final && cmd.last;
    out_item.length        = out_item.end_of_number ? cmd.length : '0;
  end

  always_comb begin
    phase_nxt = phase_r;
    zcnt_nxt  = zcnt_r;
    if (go) begin
      priority if (item_final) begin
        phase_nxt = PH_LEAD;
        zcnt_nxt  = '0;
      end else if (in_zero) begin
        zcnt_nxt = zcnt_r + 1'b1;
      end else begin
        phase_nxt = PH_TAIL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      zcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      zcnt_r  <= zcnt_nxt;
    end
  end

endmodule

### sv/multiword_stream_shifter.sv
`timescale 1ns / 1ps
// channel  direction  handshake          payload
// in       input      push / full        in_digit, in_last_digit
// out      output     pop / empty        out_digit, out_digit_valid, out_end_of_number,
//                                        out_length
// cfg      input      cfg_valid/ready    cfg_index, cfg_data
//
// one digit is taken per cycle while the request queue is not full; the back end turns
// each request into its result items one by one: a left shift puts digit_shift zero items
// (at most 62) before a number's first digit; a carry or top digit adds one on its last.
// an accepted digit's items pass the registered request queue, then the result queue.
// synchronous active-low reset clears the queues, the sequencer and the registers.
// the front end stalls only on a full request queue, the back end only on a full
// result queue; cfg_ready is always high.
module multiword_stream_shifter import mss_pkg::*; #(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [DIGIT_BITS-1:0] in_digit,
  input  logic                  in_last_digit,
  output logic                  empty,
  input  logic                  pop,
  output logic [DIGIT_BITS-1:0] out_digit,
  output logic                  out_digit_valid,
  output logic                  out_end_of_number,
  output logic [LEN_W-1:0]      out_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t      cmd_in, cmd_head;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  out_item_t item_in, item_head;
  logic      out_push, out_full;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;

  mss_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .in_digit      (in_digit),
    .in_last_digit (in_last_digit),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  mss_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  mss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (item_in)
  );

  mss_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .wr_data (item_in),
    .full    (out_full),
    .pop     (pop),
    .rd_data (item_head),
    .empty   (empty)
  );

  assign out_digit         = item_head.digit;
  assign out_digit_valid   = item_head.digit_valid;
  assign out_end_of_number = item_head.end_of_number;
  assign out_length        = item_head.length;

  // an empty result only ever closes a number
  a_invalid_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_digit_valid) |-> out_end_of_number)
    else $error("empty result item without end of number");

  // length only on the final item, never above the cap
  a_length_final: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_end_of_number) |-> (out_length == '0))
    else $error("length on a non-final item");

  a_length_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_length <= LEN_CAP))
    else $error("length above cap");

  // a request retires only together with the item that finishes it
  a_pop_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (out_push && !out_full))
    else $error("request retired without a result item");

endmodule
